// ===== hw/rtl/triangle_barycentric_coords_macros.svh =====
// assertion macros for the barycentric weight block
`ifndef TRIANGLE_BARYCENTRIC_COORDS_MACROS_SVH
`define TRIANGLE_BARYCENTRIC_COORDS_MACROS_SVH
`ifndef SYNTHESIS
`define TBC_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("tbc check failed");
`define TBC_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("tbc check failed");
`else
`define TBC_ASSERT_IMP(lbl, a, b)
`define TBC_ASSERT_NXT(lbl, a, b)
`endif
`endif

// ===== hw/rtl/tbc_pkg.sv =====
// shared types and constants of the barycentric weight block
package tbc_pkg;
  localparam int WEIGHT_W   = 32;
  localparam int OUT_DATA_W = 104;

  typedef logic [1:0] axis_t;
  localparam axis_t AX_X = 2'd0;
  localparam axis_t AX_Y = 2'd1;
  localparam axis_t AX_Z = 2'd2;

  typedef struct packed {
    logic valid;
    logic neg_a;
    logic neg_b;
    logic den_zero;
  } tbc_ctl_t;
endpackage

// ===== hw/rtl/triangle_barycentric_coords.sv =====
// barycentric weights of a point by dominant axis projection, top level
// channel | dir | contents
// in_*    | in  | tdata: v0_x v0_y v0_z v1_x v1_y v1_z v2_x v2_y v2_z point_x point_y point_z
// out_*   | out | tdata: valid_res weight_a weight_b weight_c
// one item enters per cycle while the output is not stalled; each item passes the stage
// registers, the chain of one-bit division cells and the output register
// reset clears the valid bits of every stage and the output register
// while a result waits untaken the whole chain holds and in_tready is low
module triangle_barycentric_coords #(
  parameter int COORD_BITS = 24,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, point_x, point_y, point_z
  input  logic [((12*COORD_BITS+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // valid_res, weight_a, weight_b, weight_c, zero fill
  output logic [tbc_pkg::OUT_DATA_W-1:0] out_tdata
);
  import tbc_pkg::*;
  `include "triangle_barycentric_coords_macros.svh"

  localparam int CB  = COORD_BITS;
  localparam int WF  = WEIGHT_FRAC_BITS;
  localparam int DW  = CB + 1;
  localparam int MW  = 2 * DW;
  localparam int PW  = MW + 1;
  localparam int NW  = PW + WF;
  localparam int QW  = NW + 1;
  localparam int SW  = (QW + 2 > 33) ? QW + 2 : 33;

  logic en;
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;

  // stage 1: coordinates and edge vectors
  logic signed [CB-1:0] c1_r [3][3];
  logic signed [CB-1:0] p1_r [3];
  logic signed [DW-1:0] e1_r [3];
  logic signed [DW-1:0] e2_r [3];
  logic signed [CB-1:0] cin [3][3];
  logic signed [CB-1:0] pin [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        cin[i][j] = $signed(in_tdata[(i*3+j)*CB +: CB]);
      end
      pin[i] = $signed(in_tdata[(9+i)*CB +: CB]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          c1_r[i][j] <= cin[i][j];
        end
        p1_r[j] <= pin[j];
        e1_r[j] <= DW'(cin[1][j]) - DW'(cin[0][j]);
        e2_r[j] <= DW'(cin[2][j]) - DW'(cin[1][j]);
      end
    end
  end

  // stage 2: cross product terms
  logic signed [CB-1:0] c2_r [3][3];
  logic signed [CB-1:0] p2_r [3];
  logic signed [MW-1:0] xa_r [3];
  logic signed [MW-1:0] xb_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      c2_r <= c1_r;
      p2_r <= p1_r;
      for (int j = 0; j < 3; j++) begin
        xa_r[j] <= MW'(e1_r[(j+1)%3]) * MW'(e2_r[(j+2)%3]);
        xb_r[j] <= MW'(e1_r[(j+2)%3]) * MW'(e2_r[(j+1)%3]);
      end
    end
  end

  // stage 3: normal magnitudes
  logic signed [CB-1:0] c3_r [3][3];
  logic signed [CB-1:0] p3_r [3];
  logic [PW-1:0]        an_r [3];
  logic signed [PW-1:0] nrm [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      nrm[j] = PW'(xa_r[j]) - PW'(xb_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3_r <= c2_r;
      p3_r <= p2_r;
      for (int j = 0; j < 3; j++) begin
        an_r[j] <= nrm[j][PW-1] ? PW'(-nrm[j]) : PW'(nrm[j]);
      end
    end
  end

  // stage 4: drop the dominant axis, ties to x then y
  axis_t drop;
  logic signed [CB-1:0] cu [3];
  logic signed [CB-1:0] cv [3];
  logic signed [CB-1:0] pu, pv;
  logic signed [DW-1:0] u_r [4];
  logic signed [DW-1:0] s_r [4];

  always_comb begin
    if (an_r[0] >= an_r[1] && an_r[0] >= an_r[2]) begin
      drop = AX_X;
    end else if (an_r[1] >= an_r[2]) begin
      drop = AX_Y;
    end else begin
      drop = AX_Z;
    end
    for (int i = 0; i < 3; i++) begin
      case (drop)
        AX_X: begin
          cu[i] = c3_r[i][1];
          cv[i] = c3_r[i][2];
        end
        AX_Y: begin
          cu[i] = c3_r[i][2];
          cv[i] = c3_r[i][0];
        end
        default: begin
          cu[i] = c3_r[i][0];
          cv[i] = c3_r[i][1];
        end
      endcase
    end
    case (drop)
      AX_X: begin
        pu = p3_r[1];
        pv = p3_r[2];
      end
      AX_Y: begin
        pu = p3_r[2];
        pv = p3_r[0];
      end
      default: begin
        pu = p3_r[0];
        pv = p3_r[1];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r[0] <= DW'(cu[0]) - DW'(cu[2]);
      u_r[1] <= DW'(cu[1]) - DW'(cu[2]);
      u_r[2] <= DW'(pu) - DW'(cu[0]);
      u_r[3] <= DW'(pu) - DW'(cu[2]);
      s_r[0] <= DW'(cv[0]) - DW'(cv[2]);
      s_r[1] <= DW'(cv[1]) - DW'(cv[2]);
      s_r[2] <= DW'(pv) - DW'(cv[0]);
      s_r[3] <= DW'(pv) - DW'(cv[2]);
    end
  end

  // stage 5: projected products
  logic signed [MW-1:0] m_r [6];

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0] <= MW'(s_r[0]) * MW'(u_r[1]);
      m_r[1] <= MW'(s_r[1]) * MW'(u_r[0]);
      m_r[2] <= MW'(s_r[3]) * MW'(u_r[1]);
      m_r[3] <= MW'(s_r[1]) * MW'(u_r[3]);
      m_r[4] <= MW'(s_r[0]) * MW'(u_r[2]);
      m_r[5] <= MW'(s_r[2]) * MW'(u_r[0]);
    end
  end

  // stage 6: denominator, numerators, signs and magnitudes
  logic signed [PW-1:0] den, nma, nmb;
  tbc_ctl_t             ctl6_r;
  logic [PW-1:0]        den6_r;
  logic [NW-1:0]        na6_r, nb6_r;

  always_comb begin
    den = PW'(m_r[0]) - PW'(m_r[1]);
    nma = PW'(m_r[2]) - PW'(m_r[3]);
    nmb = PW'(m_r[4]) - PW'(m_r[5]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl6_r.valid <= 1'b0;
    end else if (en) begin
      ctl6_r.valid    <= v5_r;
      ctl6_r.neg_a    <= nma[PW-1] ^ den[PW-1];
      ctl6_r.neg_b    <= nmb[PW-1] ^ den[PW-1];
      ctl6_r.den_zero <= (den == '0);
      den6_r <= den[PW-1] ? PW'(-den) : PW'(den);
      na6_r  <= {(nma[PW-1] ? PW'(-nma) : PW'(nma)), {WF{1'b0}}};
      nb6_r  <= {(nmb[PW-1] ? PW'(-nmb) : PW'(nmb)), {WF{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end
  assign v6_r = ctl6_r.valid;

  // division chain, one quotient bit per cell
  tbc_ctl_t      ctl_c [NW+1];
  logic [PW-1:0] den_c [NW+1];
  logic [PW:0]   ra_c  [NW+1];
  logic [PW:0]   rb_c  [NW+1];
  logic [NW-1:0] qa_c  [NW+1];
  logic [NW-1:0] qb_c  [NW+1];

  assign ctl_c[0] = ctl6_r;
  assign den_c[0] = den6_r;
  assign ra_c[0]  = '0;
  assign rb_c[0]  = '0;
  assign qa_c[0]  = na6_r;
  assign qb_c[0]  = nb6_r;

  for (genvar g = 0; g < NW; g++) begin : g_cell
    tbc_div_cell #(
      .NW   (NW),
      .DENW (PW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .ctl_i   (ctl_c[g]),
      .den_i   (den_c[g]),
      .rem_a_i (ra_c[g]),
      .num_a_i (qa_c[g]),
      .rem_b_i (rb_c[g]),
      .num_b_i (qb_c[g]),
      .ctl_o   (ctl_c[g+1]),
      .den_o   (den_c[g+1]),
      .rem_a_o (ra_c[g+1]),
      .num_a_o (qa_c[g+1]),
      .rem_b_o (rb_c[g+1]),
      .num_b_o (qb_c[g+1])
    );
  end

  // signs, third weight and saturation
  function automatic logic [WEIGHT_W-1:0] sat_w(input logic signed [SW-1:0] x);
    logic [SW-WEIGHT_W:0] top;
    top = x[SW-1:WEIGHT_W-1];
    if (top == '0 || top == '1) begin
      sat_w = x[WEIGHT_W-1:0];
    end else if (x[SW-1]) begin
      sat_w = {1'b1, {(WEIGHT_W-1){1'b0}}};
    end else begin
      sat_w = {1'b0, {(WEIGHT_W-1){1'b1}}};
    end
  endfunction

  tbc_ctl_t              ctl_e;
  logic signed [SW-1:0]  qa, qb, qc, one_w;
  logic                  out_vld_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  always_comb begin
    ctl_e = ctl_c[NW];
    qa    = $signed(SW'({1'b0, qa_c[NW]}));
    qb    = $signed(SW'({1'b0, qb_c[NW]}));
    if (ctl_e.neg_a) begin
      qa = -qa;
    end
    if (ctl_e.neg_b) begin
      qb = -qb;
    end
    one_w = $signed(SW'(1) <<< WF);
    qc    = one_w - qa - qb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= ctl_e.valid;
      if (ctl_e.den_zero) begin
        out_data_r <= '0;
      end else begin
        out_data_r <= OUT_DATA_W'({sat_w(qc), sat_w(qb), sat_w(qa), 1'b1});
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  logic [5:0] vld_vec;
  assign vld_vec = {v1_r, v2_r, v3_r, v4_r, v5_r, v6_r};

  `TBC_ASSERT_NXT(a_chain_holds, !in_tready, $stable(vld_vec))
  `TBC_ASSERT_IMP(a_degenerate_zero, out_tvalid && !out_tdata[0], out_tdata[3*WEIGHT_W:1] == '0)
  `TBC_ASSERT_NXT(a_last_cell_to_out, en && ctl_e.valid, out_tvalid)
endmodule

// ===== hw/rtl/tbc_div_cell.sv =====
// one restoring division step for both weight quotients
module tbc_div_cell #(
  parameter int NW = 67,
  parameter int DENW = 51
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  tbc_pkg::tbc_ctl_t ctl_i,
  input  logic [DENW-1:0]   den_i,
  input  logic [DENW:0]     rem_a_i,
  input  logic [NW-1:0]     num_a_i,
  input  logic [DENW:0]     rem_b_i,
  input  logic [NW-1:0]     num_b_i,
  output tbc_pkg::tbc_ctl_t ctl_o,
  output logic [DENW-1:0]   den_o,
  output logic [DENW:0]     rem_a_o,
  output logic [NW-1:0]     num_a_o,
  output logic [DENW:0]     rem_b_o,
  output logic [NW-1:0]     num_b_o
);
  import tbc_pkg::*;

  tbc_ctl_t        ctl_r;
  logic [DENW-1:0] den_r;
  logic [DENW:0]   rem_a_r, rem_b_r, rem_a_nxt, rem_b_nxt, sh_a, sh_b;
  logic [NW-1:0]   num_a_r, num_b_r, num_a_nxt, num_b_nxt;
  logic            ge_a, ge_b;

  always_comb begin
    sh_a = {rem_a_i[DENW-1:0], num_a_i[NW-1]};
    sh_b = {rem_b_i[DENW-1:0], num_b_i[NW-1]};
    ge_a = sh_a >= {1'b0, den_i};
    ge_b = sh_b >= {1'b0, den_i};
    rem_a_nxt = ge_a ? sh_a - {1'b0, den_i} : sh_a;
    rem_b_nxt = ge_b ? sh_b - {1'b0, den_i} : sh_b;
    num_a_nxt = {num_a_i[NW-2:0], ge_a};
    num_b_nxt = {num_b_i[NW-2:0], ge_b};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r   <= ctl_i;
      den_r   <= den_i;
      rem_a_r <= rem_a_nxt;
      rem_b_r <= rem_b_nxt;
      num_a_r <= num_a_nxt;
      num_b_r <= num_b_nxt;
    end
  end

  assign ctl_o   = ctl_r;
  assign den_o   = den_r;
  assign rem_a_o = rem_a_r;
  assign rem_b_o = rem_b_r;
  assign num_a_o = num_a_r;
  assign num_b_o = num_b_r;
endmodule

// ===== tb/triangle_barycentric_coords_tb.sv =====
// self-checking testbench of the barycentric weight block
`timescale 1ns / 1ps

module triangle_barycentric_coords_tb;
  import tbc_pkg::*;

  localparam int CB = 24;
  localparam int FB = 16;
  localparam int IN_W = ((12 * CB + 7) / 8) * 8;
  localparam int DRAIN_CYCLES = 7 + 2 * CB + 3 + FB + 40;
  localparam int N_RANDOM = 1425;
  localparam logic signed [127:0] W_MAX = 128'sd2147483647;
  localparam logic signed [127:0] W_MIN = -128'sd2147483648;

  // twelve coordinates, field 0 in the lowest bits, as on in_tdata
  typedef logic [11:0][CB-1:0] query_t;

  typedef struct packed {
    logic              ok;
    logic signed [31:0] wa;
    logic signed [31:0] wb;
    logic signed [31:0] wc;
  } weights_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, point_x, point_y, point_z
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // valid_res, weight_a, weight_b, weight_c, zero fill
  logic [OUT_DATA_W-1:0] out_tdata;

  weights_t expected_weights[$];
  int errors = 0;
  int burst_left = 0;
  int cyc = 0;

  triangle_barycentric_coords #(
    .COORD_BITS(CB),
    .WEIGHT_FRAC_BITS(FB)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  initial begin
    #3ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic signed [31:0] saturate(logic signed [127:0] v);
    if (v > W_MAX) return 32'sh7FFFFFFF;
    if (v < W_MIN) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [127:0] mag(logic signed [127:0] v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic weights_t barycentric_weights(query_t q);
    logic signed [127:0] c[3][3];
    logic signed [127:0] p[3];
    logic signed [127:0] d1[3];
    logic signed [127:0] d2[3];
    logic signed [127:0] nrm[3];
    logic signed [127:0] u1, u2, u3, u4, s1, s2, s3, s4, den, na, nb, qa, qb, qc;
    axis_t drop;
    int ua, va;
    weights_t r;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) c[i][j] = $signed(q[i * 3 + j]);
    for (int j = 0; j < 3; j++) begin
      p[j] = $signed(q[9 + j]);
      d1[j] = c[1][j] - c[0][j];
      d2[j] = c[2][j] - c[1][j];
    end
    for (int j = 0; j < 3; j++)
      nrm[j] = mag(d1[(j + 1) % 3] * d2[(j + 2) % 3] - d1[(j + 2) % 3] * d2[(j + 1) % 3]);
    // ties favor x, then y
    if (nrm[0] >= nrm[1] && nrm[0] >= nrm[2]) drop = AX_X;
    else if (nrm[1] >= nrm[2]) drop = AX_Y;
    else drop = AX_Z;
    ua = (int'(drop) + 1) % 3;
    va = (int'(drop) + 2) % 3;
    u1 = c[0][ua] - c[2][ua];
    u2 = c[1][ua] - c[2][ua];
    u3 = p[ua] - c[0][ua];
    u4 = p[ua] - c[2][ua];
    s1 = c[0][va] - c[2][va];
    s2 = c[1][va] - c[2][va];
    s3 = p[va] - c[0][va];
    s4 = p[va] - c[2][va];
    den = s1 * u2 - s2 * u1;
    r = '0;
    if (den == 0) return r;
    na = (s4 * u2 - s2 * u4) <<< FB;
    nb = (s1 * u3 - s3 * u1) <<< FB;
    qa = na / den;
    qb = nb / den;
    qc = (128'sd1 <<< FB) - qa - qb;
    r.ok = 1'b1;
    r.wa = saturate(qa);
    r.wb = saturate(qb);
    r.wc = saturate(qc);
    return r;
  endfunction

  // prediction on each accepted request, checking on each accepted result
  always @(posedge clk) begin
    weights_t e;
    weights_t a;
    cyc <= cyc + 1;
    if (rst_n && in_tvalid && in_tready)
      expected_weights.push_back(barycentric_weights(query_t'(in_tdata[12*CB-1:0])));
    if (rst_n && out_tvalid && out_tready) begin
      a.ok = out_tdata[0];
      a.wa = out_tdata[32:1];
      a.wb = out_tdata[64:33];
      a.wc = out_tdata[96:65];
      if (expected_weights.size() == 0) begin
        $display("%0t unexpected result: actual %h", $time, a);
        errors++;
      end else begin
        e = expected_weights.pop_front();
        if (a.ok !== e.ok) begin
          $display("%0t valid_res: expected %0d actual %0d", $time, e.ok, a.ok);
          errors++;
        end
        if (a.wa !== e.wa) begin
          $display("%0t weight_a: expected %0d actual %0d", $time, e.wa, a.wa);
          errors++;
        end
        if (a.wb !== e.wb) begin
          $display("%0t weight_b: expected %0d actual %0d", $time, e.wb, a.wb);
          errors++;
        end
        if (a.wc !== e.wc) begin
          $display("%0t weight_c: expected %0d actual %0d", $time, e.wc, a.wc);
          errors++;
        end
        if (out_tdata[OUT_DATA_W-1:97] !== '0) begin
          $display("%0t fill bits: expected 0 actual %h", $time, out_tdata[OUT_DATA_W-1:97]);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern, cycling through four modes
  always @(posedge clk) begin
    case ((cyc / 300) % 4)
      0: begin
        out_tready <= 1'b1;
      end
      1: begin
        out_tready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_tready <= (cyc % 4 == 0);
      end
      default: begin
        out_tready <= (cyc % 64 >= 40);
      end
    endcase
  end

  // called just after clk rises; returns once in_tready shows that the request was taken
  task automatic send_query(query_t q);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= IN_W'(q);
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic query_t make_query(int v[12]);
    query_t q;
    for (int i = 0; i < 12; i++) q[i] = v[i][CB-1:0];
    return q;
  endfunction

  function automatic int rand_full();
    return int'($signed(CB'($urandom)));
  endfunction

  task automatic test_extremes();
    int v[12];
    int mx, mn;
    mx = 8388607;
    mn = -8388608;
    v = '{mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx};
    send_query(make_query(v));
    v = '{mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn};
    send_query(make_query(v));
    v = '{mn, mn, mn, mx, mn, mn, mn, mx, mx, mx, mx, mn};
    send_query(make_query(v));
    v = '{mx, mx, mn, mn, mx, mx, mx, mn, mn, mn, mx, mx};
    send_query(make_query(v));
    v = '{0, 0, 0, 4096, 0, 0, 0, 4096, 0, 1024, 1024, 0};
    send_query(make_query(v));
    v = '{mn, 0, mx, mx, mn, 0, 0, mx, mn, mx, mn, 0};
    send_query(make_query(v));
  endtask

  task automatic test_degenerate();
    int v[12];
    v = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_query(make_query(v));
    v = '{100, 200, 300, 100, 200, 300, 100, 200, 300, 5, 6, 7};
    send_query(make_query(v));
    // collinear vertices
    v = '{0, 0, 0, 4096, 8192, -4096, 8192, 16384, -8192, 77, -3, 9};
    send_query(make_query(v));
    v = '{-8388608, 0, 0, 0, 0, 0, 8388607, 0, 0, 1, 2, 3};
    send_query(make_query(v));
  endtask

  task automatic test_axis_ties();
    int v[12];
    int s;
    s = 4096;
    // plane z fixed, x fixed, y fixed: each axis dominant
    v = '{0, 0, 100, s, 0, 100, 0, s, 100, 1000, 1000, 100};
    send_query(make_query(v));
    v = '{7, 0, 0, 7, s, 0, 7, 0, s, 7, 1000, 1000};
    send_query(make_query(v));
    v = '{0, -5, 0, 0, -5, s, s, -5, 0, 1000, -5, 1000};
    send_query(make_query(v));
    // ties of x with y, y with z, and all three
    v = '{0, 0, 0, s, -s, 0, 0, 0, s, 300, 200, 100};
    send_query(make_query(v));
    v = '{0, 0, 0, 0, s, -s, s, 0, 0, 300, 200, 100};
    send_query(make_query(v));
    v = '{s, 0, 0, 0, s, 0, 0, 0, s, 1365, 1365, 1366};
    send_query(make_query(v));
  endtask

  task automatic test_saturation();
    int v[12];
    v = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 8388607, 8388607, 0};
    send_query(make_query(v));
    v = '{0, 0, 0, 1, 0, 0, 0, 1, 0, -8388608, -8388608, 0};
    send_query(make_query(v));
    v = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 8388607, -8388608, 0};
    send_query(make_query(v));
    v = '{0, 0, 0, 2, 1, 0, 1, 1, 0, 8388607, 5, 0};
    send_query(make_query(v));
    v = '{5, 5, 5, 6, 5, 5, 5, 6, 5, -8388608, 8388607, 5};
    send_query(make_query(v));
  endtask

  task automatic test_random();
    int v[12];
    int kind, base, s, d0, d1, d2;
    for (int n = 0; n < N_RANDOM; n++) begin
      kind = $urandom_range(0, 19);
      if (kind < 9) begin
        for (int i = 0; i < 12; i++) v[i] = rand_full();
      end else if (kind < 14) begin
        // moderate triangles with points near them
        for (int i = 0; i < 12; i++) v[i] = $signed($urandom_range(0, 65535)) - 32768;
      end else if (kind < 16) begin
        // collinear vertices
        for (int j = 0; j < 3; j++) begin
          base = $signed($urandom_range(0, 2097151)) - 1048576;
          s = $signed($urandom_range(0, 1048575)) - 524288;
          v[j] = base;
          v[3 + j] = base + s;
          v[6 + j] = base - s;
          v[9 + j] = rand_full();
        end
      end else if (kind < 18) begin
        // tiny triangle, far point
        for (int j = 0; j < 3; j++) begin
          base = rand_full() / 2;
          v[j] = base;
          v[3 + j] = base + $signed($urandom_range(0, 6)) - 3;
          v[6 + j] = base + $signed($urandom_range(0, 6)) - 3;
          v[9 + j] = rand_full();
        end
      end else begin
        // normal components tied
        s = $urandom_range(1, 1000000);
        d0 = $signed($urandom_range(0, 4194303)) - 2097152;
        d1 = $signed($urandom_range(0, 4194303)) - 2097152;
        d2 = $signed($urandom_range(0, 4194303)) - 2097152;
        case ($urandom_range(0, 2))
          0: v = '{d0, d1, d2, d0 + s, d1 - s, d2, d0, d1, d2 + s, 0, 0, 0};
          1: v = '{d0, d1, d2, d0, d1 + s, d2 - s, d0 + s, d1, d2, 0, 0, 0};
          default: v = '{d0 + s, d1, d2, d0, d1 + s, d2, d0, d1, d2 + s, 0, 0, 0};
        endcase
        for (int j = 9; j < 12; j++) v[j] = $signed($urandom_range(0, 4194303)) - 2097152;
      end
      send_query(make_query(v));
    end
  endtask

  initial begin
    int waited;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_degenerate();
    test_axis_ties();
    test_saturation();
    test_random();
    in_tvalid <= 1'b0;
    waited = 0;
    while (expected_weights.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_weights.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
